// ----- rtl/core/lob_pkg.sv -----
// Shared types and codes for the limit order book matcher.
// No dependencies; every other file in rtl/core uses this package.
`default_nettype none
package lob_pkg;

    localparam int ID_FIELD_W    = 32;
    localparam int PRICE_FIELD_W = 32;
    localparam int QTY_FIELD_W   = 24;

    localparam logic CMD_ADD      = 1'b0;
    localparam logic CMD_CANCEL   = 1'b1;
    localparam logic SIDE_BUY     = 1'b0;
    localparam logic SIDE_SELL    = 1'b1;
    localparam logic KIND_LIMIT   = 1'b0;
    localparam logic KIND_MARKET  = 1'b1;

    typedef enum logic [3:0] {
        ST_TRADE     = 4'd0,
        ST_OPEN      = 4'd1,
        ST_PARTIAL   = 4'd2,
        ST_FILLED    = 4'd3,
        ST_DROPPED   = 4'd4,
        ST_DUP       = 4'd5,
        ST_FULL      = 4'd6,
        ST_CANCELLED = 4'd7,
        ST_NOTFOUND  = 4'd8
    } status_t;

    typedef struct packed {
        logic                     command;
        logic [ID_FIELD_W-1:0]    order_id;
        logic                     side;
        logic                     order_kind;
        logic [PRICE_FIELD_W-1:0] limit_price;
        logic [QTY_FIELD_W-1:0]   quantity;
    } cmd_item_t;

    typedef struct packed {
        status_t                  status;
        logic [ID_FIELD_W-1:0]    buy_id;
        logic [ID_FIELD_W-1:0]    sell_id;
        logic [ID_FIELD_W-1:0]    subject_id;
        logic [PRICE_FIELD_W-1:0] trade_price;
        logic [QTY_FIELD_W-1:0]   amount;
        logic [PRICE_FIELD_W-1:0] best_bid;
        logic                     bid_valid;
        logic [PRICE_FIELD_W-1:0] best_ask;
        logic                     ask_valid;
        logic                     last;
    } res_item_t;

    typedef struct packed {
        logic set_valid;
        logic clr_valid;
        logic wr_all;
        logic wr_rem;
    } wr_ctl_t;

    typedef struct packed {
        logic buy_found;
        logic sell_found;
        logic match_found;
        logic free_found;
    } scan_flags_t;

endpackage
`default_nettype wire

// ----- rtl/core/lob_cmd_if.sv -----
// Command channel of the order book: valid, ready and one command item.
// Depends on lob_pkg.
`default_nettype none
interface lob_cmd_if;
    logic              valid;
    logic              ready;
    lob_pkg::cmd_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/lob_res_if.sv -----
// Result channel of the order book: valid, ready and one result item.
// Depends on lob_pkg.
`default_nettype none
interface lob_res_if;
    logic              valid;
    logic              ready;
    lob_pkg::res_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/lob_book.sv -----
// Order storage: per-slot valid flags in flip-flops and entry fields in memory.
// One write and one registered read per cycle. Depends on lob_pkg.
`default_nettype none
module lob_book #(
    parameter int DEPTH   = 32,
    parameter int ID_W    = 32,
    parameter int PRICE_W = 32,
    parameter int IDX_W   = 5
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 rd_en,
    input  wire logic [IDX_W-1:0]     rd_addr,
    input  wire lob_pkg::wr_ctl_t     wr,
    input  wire logic [IDX_W-1:0]     wr_addr,
    input  wire logic [ID_W-1:0]      wr_id,
    input  wire logic                 wr_side,
    input  wire logic [PRICE_W-1:0]   wr_price,
    input  wire logic [lob_pkg::QTY_FIELD_W-1:0] wr_rem,
    input  wire logic [31:0]          wr_arrival,
    output logic                      rd_ok,
    output logic [IDX_W-1:0]          rd_idx,
    output logic                      rd_valid,
    output logic [ID_W-1:0]           rd_id,
    output logic                      rd_side,
    output logic [PRICE_W-1:0]        rd_price,
    output logic [lob_pkg::QTY_FIELD_W-1:0] rd_rem,
    output logic [31:0]               rd_arrival
);

    logic [DEPTH-1:0]                    valid_reg;
    logic [ID_W-1:0]                     id_mem      [DEPTH];
    logic                                side_mem    [DEPTH];
    logic [PRICE_W-1:0]                  price_mem   [DEPTH];
    logic [lob_pkg::QTY_FIELD_W-1:0]     rem_mem     [DEPTH];
    logic [31:0]                         arrival_mem [DEPTH];
    logic                                rd_ok_reg;
    logic                                rd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_ok_reg    <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.set_valid)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            else if (wr.clr_valid)
            begin
                valid_reg[wr_addr] <= 1'b0;
            end
            rd_ok_reg    <= rd_en;
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.wr_all)
        begin
            id_mem[wr_addr]      <= wr_id;
            side_mem[wr_addr]    <= wr_side;
            price_mem[wr_addr]   <= wr_price;
            arrival_mem[wr_addr] <= wr_arrival;
        end
        if (wr.wr_all || wr.wr_rem)
        begin
            rem_mem[wr_addr] <= wr_rem;
        end
        if (rd_en)
        begin
            rd_idx     <= rd_addr;
            rd_id      <= id_mem[rd_addr];
            rd_side    <= side_mem[rd_addr];
            rd_price   <= price_mem[rd_addr];
            rd_rem     <= rem_mem[rd_addr];
            rd_arrival <= arrival_mem[rd_addr];
        end
    end

    assign rd_ok    = rd_ok_reg;
    assign rd_valid = rd_valid_reg;

endmodule
`default_nettype wire

// ----- rtl/core/lob_scan.sv -----
// Scan unit: takes one slot a cycle and keeps the best bid, best ask, the slot
// holding the searched ID and the lowest free slot. Depends on lob_pkg.
`default_nettype none
module lob_scan #(
    parameter int ID_W    = 32,
    parameter int PRICE_W = 32,
    parameter int IDX_W   = 5
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 clear,
    input  wire logic                 in_ok,
    input  wire logic [IDX_W-1:0]     in_idx,
    input  wire logic                 in_valid,
    input  wire logic [ID_W-1:0]      in_id,
    input  wire logic                 in_side,
    input  wire logic [PRICE_W-1:0]   in_price,
    input  wire logic [lob_pkg::QTY_FIELD_W-1:0] in_rem,
    input  wire logic [31:0]          in_arrival,
    input  wire logic [31:0]          arrival_now,
    input  wire logic [ID_W-1:0]      search_id,
    output lob_pkg::scan_flags_t      flags,
    output logic [IDX_W-1:0]          buy_idx,
    output logic [ID_W-1:0]           buy_id,
    output logic [PRICE_W-1:0]        buy_price,
    output logic [lob_pkg::QTY_FIELD_W-1:0] buy_rem,
    output logic [IDX_W-1:0]          sell_idx,
    output logic [ID_W-1:0]           sell_id,
    output logic [PRICE_W-1:0]        sell_price,
    output logic [lob_pkg::QTY_FIELD_W-1:0] sell_rem,
    output logic [IDX_W-1:0]          match_idx,
    output logic [lob_pkg::QTY_FIELD_W-1:0] match_rem,
    output logic [IDX_W-1:0]          free_idx
);

    lob_pkg::scan_flags_t  flags_reg;
    logic [31:0]           buy_age_reg;
    logic [31:0]           sell_age_reg;
    logic [31:0]           in_age;
    logic                  cur_found;
    logic [PRICE_W-1:0]    cur_price;
    logic [31:0]           cur_age;
    logic                  better;
    logic                  upd_buy;
    logic                  upd_sell;
    logic                  upd_match;
    logic                  upd_free;

    // One compare unit serves both sides; the slot's side selects the best so far.
    always_comb
    begin
        in_age    = arrival_now - in_arrival;
        cur_found = (in_side == lob_pkg::SIDE_SELL) ? flags_reg.sell_found
                                                    : flags_reg.buy_found;
        cur_price = (in_side == lob_pkg::SIDE_SELL) ? sell_price : buy_price;
        cur_age   = (in_side == lob_pkg::SIDE_SELL) ? sell_age_reg : buy_age_reg;
        if (!cur_found)
        begin
            better = 1'b1;
        end
        else if (in_price != cur_price)
        begin
            better = (in_side == lob_pkg::SIDE_SELL) ? (in_price < cur_price)
                                                     : (in_price > cur_price);
        end
        else
        begin
            better = in_age > cur_age;
        end
        upd_buy   = in_ok && in_valid && better && (in_side == lob_pkg::SIDE_BUY);
        upd_sell  = in_ok && in_valid && better && (in_side == lob_pkg::SIDE_SELL);
        upd_match = in_ok && in_valid && (in_id == search_id);
        upd_free  = in_ok && !in_valid && !flags_reg.free_found;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (clear)
        begin
            flags_reg <= '0;
        end
        else
        begin
            if (upd_buy)
            begin
                flags_reg.buy_found <= 1'b1;
            end
            if (upd_sell)
            begin
                flags_reg.sell_found <= 1'b1;
            end
            if (upd_match)
            begin
                flags_reg.match_found <= 1'b1;
            end
            if (upd_free)
            begin
                flags_reg.free_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_buy)
        begin
            buy_idx     <= in_idx;
            buy_id      <= in_id;
            buy_price   <= in_price;
            buy_rem     <= in_rem;
            buy_age_reg <= in_age;
        end
        if (upd_sell)
        begin
            sell_idx     <= in_idx;
            sell_id      <= in_id;
            sell_price   <= in_price;
            sell_rem     <= in_rem;
            sell_age_reg <= in_age;
        end
        if (upd_match)
        begin
            match_idx <= in_idx;
            match_rem <= in_rem;
        end
        if (upd_free)
        begin
            free_idx <= in_idx;
        end
    end

    assign flags = flags_reg;

endmodule
`default_nettype wire

// ----- rtl/core/limit_order_book_matcher.sv -----
// Top level of the limit order book matcher: sequencer around the book store
// and the scan unit. Depends on lob_pkg, lob_cmd_if, lob_res_if, lob_book, lob_scan.
//
// Use: commands arrive on cmd (add or cancel), results leave on res. Each
// command gives one or more results; the final one carries last = 1. Every
// result carries the best bid and best ask as they stand after it.
// cmd.ready is high only while the block is idle; one command is handled at
// a time. Each pass over the book reads one slot a cycle through the scan
// unit, and every result is formed in S_DECIDE and then shown in S_EMIT until
// it is taken. A cancel takes one pass, or two when the order is found; an
// add takes one pass plus one more for every trade and for a rest.
// When res.ready is low the block holds the pending result in its output
// register and waits. After reset the book is empty, the arrival counter is
// zero and the block is ready at once; no clearing pass is needed.
`default_nettype none
module limit_order_book_matcher #(
    parameter int BOOK_DEPTH = 32,
    parameter int ID_BITS    = 32,
    parameter int PRICE_BITS = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lob_cmd_if.sink    cmd,
    lob_res_if.source  res
);

    localparam int IDX_W = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
    localparam int QW    = lob_pkg::QTY_FIELD_W;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_SCAN     = 6'b000010,
        S_SCAN_END = 6'b000100,
        S_DECIDE   = 6'b001000,
        S_EMIT     = 6'b010000,
        S_SPARE    = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    lob_pkg::cmd_item_t   item_reg, item_next;
    logic [QW-1:0]        rem_reg, rem_next;
    logic                 first_reg, first_next;
    logic                 pend_reg, pend_next;
    lob_pkg::res_item_t   stage_reg, stage_next;
    lob_pkg::res_item_t   out_reg, out_next;
    logic [31:0]          arrival_reg, arrival_next;
    logic [IDX_W-1:0]     cnt_reg, cnt_next;

    logic                 scan_clear;
    logic                 rd_en;
    lob_pkg::wr_ctl_t     wr;
    logic [IDX_W-1:0]     wr_addr;
    logic [QW-1:0]        wr_rem;

    logic                 rd_ok;
    logic [IDX_W-1:0]     rd_idx;
    logic                 rd_valid;
    logic [ID_BITS-1:0]   rd_id;
    logic                 rd_side;
    logic [PRICE_BITS-1:0] rd_price;
    logic [QW-1:0]        rd_rem;
    logic [31:0]          rd_arrival;

    lob_pkg::scan_flags_t flags;
    logic [IDX_W-1:0]     buy_idx, sell_idx, match_idx, free_idx;
    logic [ID_BITS-1:0]   buy_id, sell_id;
    logic [PRICE_BITS-1:0] buy_price, sell_price;
    logic [QW-1:0]        buy_rem, sell_rem, match_rem;

    logic [ID_BITS-1:0]   id_w;
    logic [PRICE_BITS-1:0] price_w;
    logic                 opp_found;
    logic [IDX_W-1:0]     opp_idx;
    logic [ID_BITS-1:0]   opp_id;
    logic [PRICE_BITS-1:0] opp_price;
    logic [QW-1:0]        opp_rem;
    logic                 price_ok;
    logic [QW-1:0]        trade_qty;
    logic [QW-1:0]        opp_left;
    lob_pkg::res_item_t   base;

    assign id_w    = ID_BITS'(item_reg.order_id);
    assign price_w = PRICE_BITS'(item_reg.limit_price);

    lob_book #(
        .DEPTH   (BOOK_DEPTH),
        .ID_W    (ID_BITS),
        .PRICE_W (PRICE_BITS),
        .IDX_W   (IDX_W)
    ) u_book (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (rd_en),
        .rd_addr    (cnt_reg),
        .wr         (wr),
        .wr_addr    (wr_addr),
        .wr_id      (id_w),
        .wr_side    (item_reg.side),
        .wr_price   (price_w),
        .wr_rem     (wr_rem),
        .wr_arrival (arrival_reg),
        .rd_ok      (rd_ok),
        .rd_idx     (rd_idx),
        .rd_valid   (rd_valid),
        .rd_id      (rd_id),
        .rd_side    (rd_side),
        .rd_price   (rd_price),
        .rd_rem     (rd_rem),
        .rd_arrival (rd_arrival)
    );

    lob_scan #(
        .ID_W    (ID_BITS),
        .PRICE_W (PRICE_BITS),
        .IDX_W   (IDX_W)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (scan_clear),
        .in_ok       (rd_ok),
        .in_idx      (rd_idx),
        .in_valid    (rd_valid),
        .in_id       (rd_id),
        .in_side     (rd_side),
        .in_price    (rd_price),
        .in_rem      (rd_rem),
        .in_arrival  (rd_arrival),
        .arrival_now (arrival_reg),
        .search_id   (id_w),
        .flags       (flags),
        .buy_idx     (buy_idx),
        .buy_id      (buy_id),
        .buy_price   (buy_price),
        .buy_rem     (buy_rem),
        .sell_idx    (sell_idx),
        .sell_id     (sell_id),
        .sell_price  (sell_price),
        .sell_rem    (sell_rem),
        .match_idx   (match_idx),
        .match_rem   (match_rem),
        .free_idx    (free_idx)
    );

    always_comb
    begin
        if (item_reg.side == lob_pkg::SIDE_BUY)
        begin
            opp_found = flags.sell_found;
            opp_idx   = sell_idx;
            opp_id    = sell_id;
            opp_price = sell_price;
            opp_rem   = sell_rem;
            price_ok  = price_w >= sell_price;
        end
        else
        begin
            opp_found = flags.buy_found;
            opp_idx   = buy_idx;
            opp_id    = buy_id;
            opp_price = buy_price;
            opp_rem   = buy_rem;
            price_ok  = price_w <= buy_price;
        end
        trade_qty = (rem_reg < opp_rem) ? rem_reg : opp_rem;
        opp_left  = opp_rem - trade_qty;

        base             = '0;
        base.subject_id  = lob_pkg::ID_FIELD_W'(id_w);
        base.last        = 1'b1;
        base.best_bid    = flags.buy_found ? lob_pkg::PRICE_FIELD_W'(buy_price) : '0;
        base.bid_valid   = flags.buy_found;
        base.best_ask    = flags.sell_found ? lob_pkg::PRICE_FIELD_W'(sell_price) : '0;
        base.ask_valid   = flags.sell_found;
    end

    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        rem_next     = rem_reg;
        first_next   = first_reg;
        pend_next    = pend_reg;
        stage_next   = stage_reg;
        out_next     = out_reg;
        arrival_next = arrival_reg;
        cnt_next     = cnt_reg;
        wr           = '0;
        wr_addr      = opp_idx;
        wr_rem       = opp_left;
        rd_en        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    item_next  = cmd.data;
                    rem_next   = cmd.data.quantity;
                    first_next = 1'b1;
                    pend_next  = 1'b0;
                    cnt_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                rd_en    = 1'b1;
                cnt_next = cnt_reg + IDX_W'(1);
                if (cnt_reg == IDX_W'(BOOK_DEPTH - 1))
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cnt_next   = '0;
                out_next   = base;
                state_next = S_EMIT;
                if (pend_reg)
                begin
                    out_next            = stage_reg;
                    out_next.best_bid   = base.best_bid;
                    out_next.bid_valid  = base.bid_valid;
                    out_next.best_ask   = base.best_ask;
                    out_next.ask_valid  = base.ask_valid;
                    pend_next           = 1'b0;
                end
                else if (first_reg && item_reg.command == lob_pkg::CMD_CANCEL)
                begin
                    first_next = 1'b0;
                    if (flags.match_found)
                    begin
                        wr.clr_valid      = 1'b1;
                        wr_addr           = match_idx;
                        stage_next        = base;
                        stage_next.status = lob_pkg::ST_CANCELLED;
                        stage_next.amount = match_rem;
                        pend_next         = 1'b1;
                        state_next        = S_SCAN;
                    end
                    else
                    begin
                        out_next.status = lob_pkg::ST_NOTFOUND;
                    end
                end
                else if (first_reg && flags.match_found)
                begin
                    out_next.status = lob_pkg::ST_DUP;
                    out_next.amount = item_reg.quantity;
                end
                else
                begin
                    first_next = 1'b0;
                    if (rem_reg == '0)
                    begin
                        out_next.status = lob_pkg::ST_FILLED;
                    end
                    else if (opp_found && (item_reg.order_kind == lob_pkg::KIND_MARKET
                                           || price_ok))
                    begin
                        wr.wr_rem              = 1'b1;
                        wr.clr_valid           = (opp_left == '0);
                        rem_next               = rem_reg - trade_qty;
                        stage_next             = base;
                        stage_next.status      = lob_pkg::ST_TRADE;
                        stage_next.last        = 1'b0;
                        stage_next.amount      = trade_qty;
                        stage_next.trade_price = lob_pkg::PRICE_FIELD_W'(opp_price);
                        if (item_reg.side == lob_pkg::SIDE_BUY)
                        begin
                            stage_next.buy_id  = lob_pkg::ID_FIELD_W'(id_w);
                            stage_next.sell_id = lob_pkg::ID_FIELD_W'(opp_id);
                        end
                        else
                        begin
                            stage_next.buy_id  = lob_pkg::ID_FIELD_W'(opp_id);
                            stage_next.sell_id = lob_pkg::ID_FIELD_W'(id_w);
                        end
                        pend_next  = 1'b1;
                        state_next = S_SCAN;
                    end
                    else if (item_reg.order_kind == lob_pkg::KIND_MARKET)
                    begin
                        out_next.status = lob_pkg::ST_DROPPED;
                        out_next.amount = rem_reg;
                    end
                    else if (flags.free_found)
                    begin
                        wr.set_valid      = 1'b1;
                        wr.wr_all         = 1'b1;
                        wr_addr           = free_idx;
                        wr_rem            = rem_reg;
                        arrival_next      = arrival_reg + 32'd1;
                        stage_next        = base;
                        stage_next.status = (rem_reg == item_reg.quantity) ?
                                            lob_pkg::ST_OPEN : lob_pkg::ST_PARTIAL;
                        stage_next.amount = rem_reg;
                        pend_next         = 1'b1;
                        state_next        = S_SCAN;
                    end
                    else
                    begin
                        out_next.status = lob_pkg::ST_FULL;
                        out_next.amount = rem_reg;
                    end
                end
            end
            S_EMIT:
            begin
                if (res.ready)
                begin
                    state_next = out_reg.last ? S_IDLE : S_DECIDE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign scan_clear = (state_next == S_SCAN) && (state_reg != S_SCAN);
    assign cmd.ready  = (state_reg == S_IDLE);
    assign res.valid  = (state_reg == S_EMIT);
    assign res.data   = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            first_reg   <= 1'b0;
            pend_reg    <= 1'b0;
            arrival_reg <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            first_reg   <= first_next;
            pend_reg    <= pend_next;
            arrival_reg <= arrival_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        rem_reg   <= rem_next;
        stage_reg <= stage_next;
        out_reg   <= out_next;
    end

    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.ready && res.valid))
        else $error("command taken while a result is pending");

    a_arrival_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(arrival_reg) |-> $past(state_reg == S_DECIDE))
        else $error("arrival counter moved outside a decision");

    a_trade_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.data.status == lob_pkg::ST_TRADE) |-> !res.data.last)
        else $error("trade result marked last");

    a_outcome_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.data.status != lob_pkg::ST_TRADE) |-> res.data.last)
        else $error("outcome result not marked last");

    a_bid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.data.bid_valid) |-> (res.data.best_bid == '0))
        else $error("best bid shown without a resting buy order");

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for limit_order_book_matcher: directed and random
// add and cancel commands, each result checked against an order book model.
// Depends on lob_pkg, lob_cmd_if, lob_res_if and the matcher RTL.
`timescale 1ns / 1ps
module testbench;

    localparam int DEPTH = 32;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lob_cmd_if cmd ();
    lob_res_if res ();

    limit_order_book_matcher dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd.sink),
        .res   (res.source)
    );

    always #5 clk = ~clk;

    // Book model.
    logic        bk_valid [DEPTH];
    logic [31:0] bk_id [DEPTH];
    logic        bk_side [DEPTH];
    logic [31:0] bk_price [DEPTH];
    logic [23:0] bk_rem [DEPTH];
    logic [31:0] bk_arrival [DEPTH];
    logic [31:0] arrival_count;

    lob_pkg::cmd_item_t pending_cmds[$];
    lob_pkg::res_item_t expected_results[$];
    int        errors;
    int        send_idle_pct;
    int        recv_idle_pct;
    logic      hold_send;

    function automatic int best_slot(logic s);
        int b;
        b = -1;
        for (int i = 0; i < DEPTH; i++) begin
            if (!bk_valid[i] || bk_side[i] != s) continue;
            if (b < 0) b = i;
            else if (bk_price[i] != bk_price[b]) begin
                if (s == lob_pkg::SIDE_BUY ? bk_price[i] > bk_price[b]
                                           : bk_price[i] < bk_price[b])
                    b = i;
            end else if (32'(arrival_count - bk_arrival[i]) >
                         32'(arrival_count - bk_arrival[b]))
                b = i;
        end
        return b;
    endfunction

    function automatic int find_order(logic [31:0] id);
        for (int i = 0; i < DEPTH; i++)
            if (bk_valid[i] && bk_id[i] == id) return i;
        return -1;
    endfunction

    function automatic void push_result(lob_pkg::status_t st, logic [31:0] buy,
                                        logic [31:0] sell, logic [31:0] subj,
                                        logic [31:0] px, logic [23:0] amt, logic last);
        lob_pkg::res_item_t r;
        int bb;
        int ba;
        bb = best_slot(lob_pkg::SIDE_BUY);
        ba = best_slot(lob_pkg::SIDE_SELL);
        r.status = st;
        r.buy_id = buy;
        r.sell_id = sell;
        r.subject_id = subj;
        r.trade_price = px;
        r.amount = amt;
        r.bid_valid = bb >= 0;
        r.best_bid = bb >= 0 ? bk_price[bb] : 32'd0;
        r.ask_valid = ba >= 0;
        r.best_ask = ba >= 0 ? bk_price[ba] : 32'd0;
        r.last = last;
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic void predict_book(lob_pkg::cmd_item_t c);
        int i;
        int b;
        int f;
        logic [23:0] left;
        logic [23:0] t;
        i = find_order(c.order_id);
        if (c.command == lob_pkg::CMD_CANCEL) begin
            if (i < 0) push_result(lob_pkg::ST_NOTFOUND, 32'd0, 32'd0, c.order_id, 32'd0,
                                   24'd0, 1'b1);
            else begin
                bk_valid[i] = 1'b0;
                push_result(lob_pkg::ST_CANCELLED, 32'd0, 32'd0, c.order_id, 32'd0,
                            bk_rem[i], 1'b1);
            end
            return;
        end
        if (i >= 0) begin
            push_result(lob_pkg::ST_DUP, 32'd0, 32'd0, c.order_id, 32'd0, c.quantity, 1'b1);
            return;
        end
        left = c.quantity;
        while (left > 0) begin
            b = best_slot(~c.side);
            if (b < 0) break;
            if (c.order_kind == lob_pkg::KIND_LIMIT) begin
                if (c.side == lob_pkg::SIDE_BUY && c.limit_price < bk_price[b]) break;
                if (c.side == lob_pkg::SIDE_SELL && c.limit_price > bk_price[b]) break;
            end
            t = left < bk_rem[b] ? left : bk_rem[b];
            left -= t;
            bk_rem[b] -= t;
            if (bk_rem[b] == 0) bk_valid[b] = 1'b0;
            push_result(lob_pkg::ST_TRADE, c.side == lob_pkg::SIDE_BUY ? c.order_id : bk_id[b],
                        c.side == lob_pkg::SIDE_BUY ? bk_id[b] : c.order_id, c.order_id,
                        bk_price[b], t, 1'b0);
        end
        if (left == 0)
            push_result(lob_pkg::ST_FILLED, 32'd0, 32'd0, c.order_id, 32'd0, 24'd0, 1'b1);
        else if (c.order_kind == lob_pkg::KIND_MARKET)
            push_result(lob_pkg::ST_DROPPED, 32'd0, 32'd0, c.order_id, 32'd0, left, 1'b1);
        else begin
            f = -1;
            for (int k = 0; k < DEPTH; k++)
                if (!bk_valid[k]) begin
                    f = k;
                    break;
                end
            if (f < 0)
                push_result(lob_pkg::ST_FULL, 32'd0, 32'd0, c.order_id, 32'd0, left, 1'b1);
            else begin
                bk_valid[f] = 1'b1;
                bk_id[f] = c.order_id;
                bk_side[f] = c.side;
                bk_price[f] = c.limit_price;
                bk_rem[f] = left;
                bk_arrival[f] = arrival_count;
                arrival_count++;
                push_result(left == c.quantity ? lob_pkg::ST_OPEN : lob_pkg::ST_PARTIAL,
                            32'd0, 32'd0, c.order_id, 32'd0, left, 1'b1);
            end
        end
    endfunction

    function automatic lob_pkg::cmd_item_t make_cmd(logic op, logic [31:0] id, logic sd,
                                                    logic kd, logic [31:0] px,
                                                    logic [23:0] q);
        lob_pkg::cmd_item_t c;
        c.command = op;
        c.order_id = id;
        c.side = sd;
        c.order_kind = kd;
        c.limit_price = px;
        c.quantity = q;
        return c;
    endfunction

    // Driver.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cmd.valid <= 1'b0;
            cmd.data <= '0;
        end else begin
            if (cmd.valid && cmd.ready) begin
                predict_book(cmd.data);
                pending_cmds.delete(0);
            end
            if (cmd.valid && !cmd.ready) begin
            end else if (pending_cmds.size() > 0 &&
                         !hold_send && $urandom_range(99) >= send_idle_pct) begin
                cmd.valid <= 1'b1;
                cmd.data <= pending_cmds[0];
            end else begin
                cmd.valid <= 1'b0;
            end
        end
    end

    // Monitor.
    always @(posedge clk or negedge rst_n) begin
        lob_pkg::res_item_t e;
        if (!rst_n) begin
            res.ready <= 1'b0;
        end else begin
            if (res.valid && res.ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result, status %0d", res.data.status);
                    errors++;
                end else begin
                    e = expected_results[0];
                    expected_results.delete(0);
                    if (res.data !== e) begin
                        errors++;
                        if (res.data.status !== e.status)
                            $error("status expected %0d actual %0d", e.status, res.data.status);
                        if (res.data.buy_id !== e.buy_id)
                            $error("buy_id expected %0h actual %0h", e.buy_id, res.data.buy_id);
                        if (res.data.sell_id !== e.sell_id)
                            $error("sell_id expected %0h actual %0h", e.sell_id,
                                   res.data.sell_id);
                        if (res.data.subject_id !== e.subject_id)
                            $error("subject_id expected %0h actual %0h", e.subject_id,
                                   res.data.subject_id);
                        if (res.data.trade_price !== e.trade_price)
                            $error("trade_price expected %0h actual %0h", e.trade_price,
                                   res.data.trade_price);
                        if (res.data.amount !== e.amount)
                            $error("amount expected %0h actual %0h", e.amount, res.data.amount);
                        if (res.data.best_bid !== e.best_bid)
                            $error("best_bid expected %0h actual %0h", e.best_bid,
                                   res.data.best_bid);
                        if (res.data.bid_valid !== e.bid_valid)
                            $error("bid_valid expected %0b actual %0b", e.bid_valid,
                                   res.data.bid_valid);
                        if (res.data.best_ask !== e.best_ask)
                            $error("best_ask expected %0h actual %0h", e.best_ask,
                                   res.data.best_ask);
                        if (res.data.ask_valid !== e.ask_valid)
                            $error("ask_valid expected %0b actual %0b", e.ask_valid,
                                   res.data.ask_valid);
                        if (res.data.last !== e.last)
                            $error("last expected %0b actual %0b", e.last, res.data.last);
                    end
                end
            end
            res.ready <= $urandom_range(99) >= recv_idle_pct;
        end
    end

    function automatic lob_pkg::cmd_item_t random_cmd(ref logic [31:0] used_ids[$]);
        logic [31:0] id;
        logic [31:0] px;
        logic [23:0] q;
        int r;
        r = $urandom_range(99);
        if (r < 4) id = $urandom;
        else if (used_ids.size() > 0 && r < 30) id = used_ids[$urandom_range(used_ids.size() - 1)];
        else id = $urandom_range(200);
        if ($urandom_range(9) == 0) px = $urandom;
        else px = 32'd1000 + $urandom_range(8);
        if ($urandom_range(19) == 0) q = 24'($urandom);
        else if ($urandom_range(9) == 0) q = 24'hFFFF00 | 24'($urandom_range(255));
        else q = 24'($urandom_range(50));
        used_ids.insert(used_ids.size(), id);
        if (used_ids.size() > 64) used_ids.delete(0);
        return make_cmd($urandom_range(99) < 20, id, 1'($urandom_range(1)),
                        $urandom_range(99) < 12, px, q);
    endfunction

    task automatic run_phase(int s_pct, int r_pct, int count, ref logic [31:0] used_ids[$]);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int n = 0; n < count; n++)
            pending_cmds.insert(pending_cmds.size(), random_cmd(used_ids));
        while (pending_cmds.size() > 0) @(posedge clk);
    endtask

    task automatic queue_cmd(lob_pkg::cmd_item_t c);
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    initial begin
        logic [31:0] used_ids[$];
        errors = 0;
        hold_send = 1'b0;
        send_idle_pct = 21;
        recv_idle_pct = 64;
        arrival_count = '0;
        for (int i = 0; i < DEPTH; i++) bk_valid[i] = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        queue_cmd(make_cmd(lob_pkg::CMD_CANCEL, 32'd7, 1'b0, 1'b0, 32'd0, 24'd0));
        queue_cmd(make_cmd(lob_pkg::CMD_ADD, 32'd0, lob_pkg::SIDE_BUY, lob_pkg::KIND_LIMIT,
                           32'd0, 24'd0));
        queue_cmd(make_cmd(lob_pkg::CMD_ADD, 32'd1, lob_pkg::SIDE_BUY, lob_pkg::KIND_MARKET,
                           32'd5, 24'd9));
        queue_cmd(make_cmd(lob_pkg::CMD_ADD, 32'hFFFFFFFF, lob_pkg::SIDE_SELL,
                           lob_pkg::KIND_LIMIT, 32'hFFFFFFFF, 24'hFFFFFF));
        queue_cmd(make_cmd(lob_pkg::CMD_ADD, 32'hFFFFFFFF, lob_pkg::SIDE_BUY,
                           lob_pkg::KIND_LIMIT, 32'd3, 24'd4));
        queue_cmd(make_cmd(lob_pkg::CMD_ADD, 32'd10, lob_pkg::SIDE_SELL, lob_pkg::KIND_LIMIT,
                           32'd100, 24'd5));
        queue_cmd(make_cmd(lob_pkg::CMD_ADD, 32'd11, lob_pkg::SIDE_SELL, lob_pkg::KIND_LIMIT,
                           32'd100, 24'd5));
        queue_cmd(make_cmd(lob_pkg::CMD_ADD, 32'd12, lob_pkg::SIDE_BUY, lob_pkg::KIND_LIMIT,
                           32'd0, 24'd3));
        queue_cmd(make_cmd(lob_pkg::CMD_ADD, 32'd13, lob_pkg::SIDE_BUY, lob_pkg::KIND_LIMIT,
                           32'd100, 24'd7));
        queue_cmd(make_cmd(lob_pkg::CMD_ADD, 32'd14, lob_pkg::SIDE_BUY, lob_pkg::KIND_MARKET,
                           32'd0, 24'd9));
        queue_cmd(make_cmd(lob_pkg::CMD_ADD, 32'd15, lob_pkg::SIDE_SELL, lob_pkg::KIND_MARKET,
                           32'hFFFFFFFF, 24'd20));
        queue_cmd(make_cmd(lob_pkg::CMD_CANCEL, 32'hFFFFFFFF, 1'b1, 1'b1, 32'd1, 24'd1));
        queue_cmd(make_cmd(lob_pkg::CMD_CANCEL, 32'd12, 1'b0, 1'b0, 32'd0, 24'd0));
        for (int n = 0; n < 33; n++)
            queue_cmd(make_cmd(lob_pkg::CMD_ADD, 32'd100 + n, lob_pkg::SIDE_SELL,
                               lob_pkg::KIND_LIMIT, 32'd50 + n % 3, 24'd1));
        queue_cmd(make_cmd(lob_pkg::CMD_ADD, 32'd300, lob_pkg::SIDE_BUY, lob_pkg::KIND_LIMIT,
                           32'd60, 24'd40));
        while (pending_cmds.size() > 0) @(posedge clk);

        hold_send = 1'b1;
        while (expected_results.size() > 0) @(posedge clk);
        hold_send = 1'b0;

        run_phase(21, 64, 120, used_ids);
        run_phase(64, 21, 120, used_ids);
        run_phase(0, 0, 113, used_ids);

        while (expected_results.size() > 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("PASS limit_order_book_matcher");
        else
            $display("FAIL limit_order_book_matcher");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL limit_order_book_matcher");
        $finish;
    end
endmodule
